### hdl/bitvector_operator_alu_defines.svh
// ----------------------------------------------------------------------------
// bitvector_operator_alu_defines
// assertion macros shared by the bit-vector operator unit
// ----------------------------------------------------------------------------
`ifndef BITVECTOR_OPERATOR_ALU_DEFINES_SVH
`define BITVECTOR_OPERATOR_ALU_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg
// operator codes, error codes and helpers of the bit-vector operator unit
// ----------------------------------------------------------------------------
`default_nettype none

package bva_pkg;

    localparam int DATA_W = 64;
    localparam int WID_W  = 7;

    typedef enum logic [4:0] {
        OP_NOT     = 5'd0,
        OP_NEG     = 5'd1,
        OP_AND     = 5'd2,
        OP_OR      = 5'd3,
        OP_XOR     = 5'd4,
        OP_ADD     = 5'd5,
        OP_SUB     = 5'd6,
        OP_MUL     = 5'd7,
        OP_UDIV    = 5'd8,
        OP_UREM    = 5'd9,
        OP_SDIV    = 5'd10,
        OP_SREM    = 5'd11,
        OP_SHL     = 5'd12,
        OP_LSHR    = 5'd13,
        OP_ASHR    = 5'd14,
        OP_EQ      = 5'd15,
        OP_ULT     = 5'd16,
        OP_ULE     = 5'd17,
        OP_SLT     = 5'd18,
        OP_SLE     = 5'd19,
        OP_UADDO   = 5'd20,
        OP_USUBO   = 5'd21,
        OP_SADDO   = 5'd22,
        OP_SSUBO   = 5'd23,
        OP_UMULO   = 5'd24,
        OP_SMULHI  = 5'd25,
        OP_SMULLO  = 5'd26,
        OP_ITE     = 5'd27,
        OP_CONCAT  = 5'd28,
        OP_EXTRACT = 5'd29,
        OP_ZEXT    = 5'd30,
        OP_SEXT    = 5'd31
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_MISMATCH = 2'd1,
        ERR_RANGE    = 2'd2
    } err_t;

    // low w bits set
    function automatic logic [DATA_W-1:0] wmask(input logic [WID_W-1:0] w);
        logic [DATA_W-1:0] m;
        if (w >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << w) - 64'd1;
        end
        return m;
    endfunction

    // sign bit position of a w-bit value
    function automatic logic [DATA_W-1:0] topmask(input logic [WID_W-1:0] w);
        return 64'd1 << (w - 7'd1);
    endfunction

    // decoded operands after the first stage
    typedef struct packed {
        op_t               op;
        err_t              err;
        logic [WID_W-1:0]  w;
        logic [WID_W-1:0]  wb;
        logic [WID_W-1:0]  tw;
        logic [WID_W-1:0]  pos;
        logic              c;
        logic              sa;
        logic              sb;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } dec_t;

    // plain results and partial products
    typedef struct packed {
        op_t               op;
        err_t              err;
        logic [WID_W-1:0]  rw;
        logic [WID_W-1:0]  w;
        logic              sa;
        logic              sb;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] pp00;
        logic [DATA_W-1:0] pp01;
        logic [DATA_W-1:0] pp10;
        logic [DATA_W-1:0] pp11;
    } prod_t;

    // partially summed product
    typedef struct packed {
        op_t               op;
        err_t              err;
        logic [WID_W-1:0]  rw;
        logic [WID_W-1:0]  w;
        logic              sa;
        logic              sb;
        logic [DATA_W-1:0] res;
        logic [34:0]       mid;
        logic [31:0]       lo_low;
        logic [DATA_W-1:0] hsum;
    } psum_t;

    // everything but the division, waiting for the divider
    typedef struct packed {
        op_t               op;
        err_t              err;
        logic [WID_W-1:0]  rw;
        logic [WID_W-1:0]  w;
        logic              sa;
        logic              sb;
        logic [DATA_W-1:0] res;
    } early_t;

endpackage

`default_nettype wire

### hdl/bva_div_pipe.sv
// ----------------------------------------------------------------------------
// bva_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module bva_div_pipe #(
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic      [DW-1:0] quotient,
    output logic      [DW-1:0] remainder
);

    logic [DW-1:0] rem_reg [DW];
    logic [DW-1:0] quo_reg [DW];
    logic [DW-1:0] dvd_reg [DW];
    logic [DW-1:0] dvs_reg [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [DW-1:0] quo_in;
            logic [DW-1:0] dvd_in;
            logic [DW-1:0] dvs_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [DW-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
                assign dvd_in = dividend;
                assign dvs_in = divisor;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign dvd_in = dvd_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
            end

            // a zero divisor always subtracts: all-ones quotient, dividend left
            always_comb
            begin
                trial    = {rem_in, dvd_in[DW-1]};
                diff     = trial - {1'b0, dvs_in};
                ge       = (trial >= {1'b0, dvs_in});
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_next = {quo_in[DW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    quo_reg[k] <= quo_next;
                    dvd_reg[k] <= {dvd_in[DW-2:0], 1'b0};
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient  = quo_reg[DW-1];
    assign remainder = rem_reg[DW-1];

endmodule

`default_nettype wire

### hdl/bitvector_operator_alu.sv
// ----------------------------------------------------------------------------
// bitvector_operator_alu
// bit-vector operator unit with smt-lib semantics, fully pipelined
// the pipeline depth follows LIMIT_W = min(MAX_WIDTH, 64), the width of the
//   one-bit-per-stage divider
// throughput: one transaction per cycle; a stalled output holds the whole pipe
// reset: rst_n clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitvector_operator_alu_defines.svh"

module bitvector_operator_alu
    import bva_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [4:0]  func,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic        cond,
    input  wire logic [6:0]  width_a,
    input  wire logic [6:0]  width_b,
    input  wire logic [6:0]  bit_position,
    input  wire logic [6:0]  target_width,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result,
    output logic [6:0]       result_width,
    output logic [1:0]       error
);

    localparam int LIMIT_W = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int DW      = LIMIT_W;
    localparam int DEPTH   = DW + 2;
    localparam int DLY     = DW - 2;

    function automatic logic width_ok(input logic [WID_W-1:0] w);
        return (w != 7'd0) && (w <= 7'(LIMIT_W));
    endfunction

    logic    adv;
    logic    vld_reg [DEPTH];
    dec_t    dec_reg, dec_next;
    prod_t   prod_reg, prod_next;
    psum_t   psum_reg, psum_next;
    early_t  early_next;
    early_t  early_reg [DLY];
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
    logic [63:0]   result_reg, result_next;
    logic [6:0]    rw_reg, rw_next;
    err_t          err_reg, err_next;

    // whole pipe moves unless a finished transaction is held at the output
    assign adv      = !vld_reg[DEPTH-1] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: width checks, masking, magnitudes
    always_comb
    begin
        op_t         op;
        logic        unary;
        logic        signed_op;
        logic [63:0] ma, mb, am, bm;
        op        = op_t'(func);
        unary     = (op <= OP_NEG) || (op >= OP_EXTRACT);
        signed_op = (op == OP_SDIV) || (op == OP_SREM) ||
                    (op == OP_SMULHI) || (op == OP_SMULLO);
        ma = wmask(width_a);
        mb = wmask(width_b);
        am = operand_a & ma;
        bm = operand_b & mb;

        dec_next.op = op;
        if (!width_ok(width_a) || (!unary && !width_ok(width_b)) ||
            ((op >= OP_EXTRACT) && !width_ok(target_width)) ||
            ((op == OP_CONCAT) && (({1'b0, width_a} + {1'b0, width_b}) > 8'(LIMIT_W))))
        begin
            dec_next.err = ERR_RANGE;
        end
        else if (!unary && (op != OP_CONCAT) && (width_a != width_b))
        begin
            dec_next.err = ERR_MISMATCH;
        end
        else
        begin
            dec_next.err = ERR_NONE;
        end
        dec_next.w   = width_a;
        dec_next.wb  = width_b;
        dec_next.tw  = target_width;
        dec_next.pos = bit_position;
        dec_next.c   = cond;
        dec_next.sa  = |(am & topmask(width_a));
        dec_next.sb  = |(bm & topmask(width_b));
        dec_next.a   = am;
        dec_next.b   = bm;
        // operands of divider and multiplier, magnitudes for signed forms
        dec_next.x   = (signed_op && dec_next.sa) ? ((64'd0 - am) & ma) : am;
        dec_next.y   = ((signed_op && dec_next.sb) ? (64'd0 - bm) : bm) & ma;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dec_reg <= dec_next;
        end
    end

    // ---------------- stage 2: plain operators and partial products
    always_comb
    begin
        logic [63:0] m, flip, sum, dif, sext_a, res;
        logic [6:0]  shamt;
        logic        b_big;
        m      = wmask(dec_reg.w);
        flip   = topmask(dec_reg.w);
        sum    = dec_reg.a + dec_reg.b;
        dif    = dec_reg.a - dec_reg.b;
        sext_a = dec_reg.sa ? (dec_reg.a | ~m) : dec_reg.a;
        shamt  = dec_reg.b[6:0];
        b_big  = dec_reg.b >= 64'(dec_reg.w);
        res    = '0;

        case (dec_reg.op) inside
            OP_NOT:    res = ~dec_reg.a & m;
            OP_NEG:    res = (64'd0 - dec_reg.a) & m;
            OP_AND:    res = dec_reg.a & dec_reg.b;
            OP_OR:     res = dec_reg.a | dec_reg.b;
            OP_XOR:    res = dec_reg.a ^ dec_reg.b;
            OP_ADD:    res = sum & m;
            OP_SUB:    res = dif & m;
            OP_SHL:    res = b_big ? 64'd0 : ((dec_reg.a << shamt) & m);
            OP_LSHR:   res = b_big ? 64'd0 : (dec_reg.a >> shamt);
            OP_ASHR:   res = b_big ? (dec_reg.sa ? m : 64'd0)
                                   : (64'($signed(sext_a) >>> shamt) & m);
            OP_EQ:     res = 64'(dec_reg.a == dec_reg.b);
            OP_ULT, OP_USUBO:
                       res = 64'(dec_reg.a < dec_reg.b);
            OP_ULE:    res = 64'(dec_reg.a <= dec_reg.b);
            OP_SLT:    res = 64'((dec_reg.a ^ flip) < (dec_reg.b ^ flip));
            OP_SLE:    res = 64'((dec_reg.a ^ flip) <= (dec_reg.b ^ flip));
            OP_UADDO:  res = 64'(dec_reg.a > (m - dec_reg.b));
            OP_SADDO:  res = 64'((dec_reg.sa == dec_reg.sb) &&
                                 ((|(sum & flip)) != dec_reg.sa));
            OP_SSUBO:  res = 64'((dec_reg.sa != dec_reg.sb) &&
                                 ((|(dif & flip)) != dec_reg.sa));
            OP_ITE:    res = dec_reg.c ? dec_reg.a : dec_reg.b;
            OP_CONCAT: res = (dec_reg.a << dec_reg.wb) | dec_reg.b;
            OP_EXTRACT:
                       res = dec_reg.pos[6] ? 64'd0
                             : ((dec_reg.a >> dec_reg.pos[5:0]) & wmask(dec_reg.tw));
            OP_ZEXT:   res = dec_reg.a & wmask(dec_reg.tw);
            OP_SEXT:   res = sext_a & wmask(dec_reg.tw);
            default:   res = '0;
        endcase

        prod_next.op  = dec_reg.op;
        prod_next.err = dec_reg.err;
        prod_next.w   = dec_reg.w;
        prod_next.sa  = dec_reg.sa;
        prod_next.sb  = dec_reg.sb;
        prod_next.res = res;
        if (dec_reg.err != ERR_NONE)
        begin
            prod_next.rw = 7'd1;
        end
        else
        begin
            case (dec_reg.op) inside
                [OP_NOT:OP_ASHR], OP_ITE:
                    prod_next.rw = dec_reg.w;
                OP_CONCAT:
                    prod_next.rw = 7'(dec_reg.w + dec_reg.wb);
                [OP_EXTRACT:OP_SEXT]:
                    prod_next.rw = dec_reg.tw;
                default:
                    prod_next.rw = 7'd1;
            endcase
        end
        prod_next.pp00 = dec_reg.x[31:0]  * dec_reg.y[31:0];
        prod_next.pp01 = dec_reg.x[31:0]  * dec_reg.y[63:32];
        prod_next.pp10 = dec_reg.x[63:32] * dec_reg.y[31:0];
        prod_next.pp11 = dec_reg.x[63:32] * dec_reg.y[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    // ---------------- stage 3: sum partial products
    always_comb
    begin
        psum_next.op     = prod_reg.op;
        psum_next.err    = prod_reg.err;
        psum_next.rw     = prod_reg.rw;
        psum_next.w      = prod_reg.w;
        psum_next.sa     = prod_reg.sa;
        psum_next.sb     = prod_reg.sb;
        psum_next.res    = prod_reg.res;
        psum_next.mid    = 35'(prod_reg.pp00[63:32]) + 35'(prod_reg.pp01[31:0])
                         + 35'(prod_reg.pp10[31:0]);
        psum_next.lo_low = prod_reg.pp00[31:0];
        psum_next.hsum   = prod_reg.pp11 + 64'(prod_reg.pp01[63:32])
                         + 64'(prod_reg.pp10[63:32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psum_reg <= psum_next;
        end
    end

    // ---------------- stage 4: product result and product flags
    always_comb
    begin
        logic [63:0] hi, lo, m, flip;
        logic        hi_nz, negp;
        hi    = psum_reg.hsum + 64'(psum_reg.mid[34:32]);
        lo    = {psum_reg.mid[31:0], psum_reg.lo_low};
        m     = wmask(psum_reg.w);
        flip  = topmask(psum_reg.w);
        hi_nz = hi != 64'd0;
        negp  = psum_reg.sa != psum_reg.sb;

        early_next.op  = psum_reg.op;
        early_next.err = psum_reg.err;
        early_next.rw  = psum_reg.rw;
        early_next.w   = psum_reg.w;
        early_next.sa  = psum_reg.sa;
        early_next.sb  = psum_reg.sb;
        case (psum_reg.op)
            OP_MUL:    early_next.res = lo & m;
            OP_UMULO:  early_next.res = 64'(hi_nz || (lo > m));
            OP_SMULHI: early_next.res = 64'(!negp && (hi_nz || (lo >= flip)));
            OP_SMULLO: early_next.res = 64'(negp && (hi_nz || (lo > flip)));
            default:   early_next.res = psum_reg.res;
        endcase
    end

    // wait for the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            early_reg[0] <= early_next;
            for (int i = 1; i < DLY; i++)
            begin
                early_reg[i] <= early_reg[i-1];
            end
        end
    end

    bva_div_pipe #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .en        (adv),
        .dividend  (dec_reg.x[DW-1:0]),
        .divisor   (dec_reg.y[DW-1:0]),
        .quotient  (quo),
        .remainder (rem)
    );

    // ---------------- last stage: sign fix of division, error override
    always_comb
    begin
        early_t      e;
        logic [63:0] m, q, r;
        e = early_reg[DLY-1];
        m = wmask(e.w);
        q = 64'(quo);
        r = 64'(rem);
        case (e.op)
            OP_UDIV: result_next = q & m;
            OP_UREM: result_next = r;
            OP_SDIV: result_next = (e.sa != e.sb) ? ((64'd0 - q) & m) : (q & m);
            OP_SREM: result_next = e.sa ? ((64'd0 - r) & m) : r;
            default: result_next = e.res;
        endcase
        if (e.err != ERR_NONE)
        begin
            result_next = '0;
        end
        rw_next  = e.rw;
        err_next = e.err;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
            rw_reg     <= rw_next;
            err_reg    <= err_next;
        end
    end

    assign out_valid    = vld_reg[DEPTH-1];
    assign result       = result_reg;
    assign result_width = rw_reg;
    assign error        = err_reg;

    `BVA_ASSERT_NOW(a_err_result, out_valid && (error != ERR_NONE),
        (result == 64'd0) && (result_width == 7'd1), "error result not cleared")
    `BVA_ASSERT_NOW(a_result_masked, out_valid && (error == ERR_NONE),
        ((result & ~wmask(result_width)) == 64'd0) && (result_width != 7'd0),
        "result exceeds its width")
    `BVA_ASSERT_NOW(a_operands_fit, vld_reg[0] && (dec_reg.err == ERR_NONE),
        ((dec_reg.x | dec_reg.y) & ~wmask(dec_reg.w)) == 64'd0,
        "divider operand wider than the operand width")

endmodule

`default_nettype wire
